FILE: hdl/rppl_pkg.sv
// Shared types and constants for the row projection peak locator.
// No dependencies; imported by every module of the block.
package rppl_pkg;

  localparam int PIX_W    = 8;   // grey level width
  localparam int SUM_W    = 18;  // row accumulator width
  localparam int MEAN_W   = 8;   // row mean width
  localparam int ROWNUM_W = 10;  // reported row number width
  localparam int CFG_W    = 11;  // configuration data width
  localparam int CFG_IDX_W = 1;  // configuration register index width
  localparam int STEP_W   = $clog2(MEAN_W);  // divider step counter width

  localparam logic [CFG_W-1:0] ROW_WIDTH_RST = CFG_W'(640);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_WIDTH = 1'b0,
    REG_DIFF_MODE = 1'b1
  } cfg_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN,
    ST_ROW,
    ST_REP
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;      // accept a pixel request
    logic div_step;  // run one quotient bit
    logic finish;    // close the row: mean, peak, row counter
    logic show_rep;  // present the peak report on the output
    logic clear;     // clear all frame state
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic row_end;   // pixel on the input completes a row
    logic div_last;  // divider is on its final step
    logic fend;      // held pixel request carried frame end
  } dp_stat_t;

endpackage

FILE: hdl/rppl_ctrl.sv
// Controller state machine for the row projection peak locator.
// Depends on rppl_pkg; drives datapath commands and channel handshakes.
module rppl_ctrl
  import rppl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_frame_end,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  state_t state_r, state_nxt;

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.row_end) begin
            state_nxt = ST_DIV;
          end else if (in_frame_end) begin
            state_nxt = ST_REP;
          end
        end
      end
      ST_DIV: begin
        if (stat.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: state_nxt = ST_ROW;
      ST_ROW: begin
        if (out_ready) begin
          state_nxt = stat.fend ? ST_REP : ST_IDLE;
        end
      end
      ST_REP: begin
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    out_valid     = (state_r == ST_ROW) || (state_r == ST_REP);
    cmd.take      = (state_r == ST_IDLE) && in_valid;
    cmd.div_step  = (state_r == ST_DIV);
    cmd.finish    = (state_r == ST_FIN);
    cmd.show_rep  = (state_r == ST_REP);
    cmd.clear     = (state_r == ST_REP) && out_ready;
  end

endmodule

FILE: hdl/rppl_dp.sv
// Datapath: row accumulator, bit-serial mean divider, peak tracker, result fields.
// Depends on rppl_pkg; commanded by rppl_ctrl.
module rppl_dp
  import rppl_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 1024
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [CFG_W-1:0]    row_width,
  input  logic                diff_mode,
  input  logic [PIX_W-1:0]    in_pixel,
  input  logic                in_frame_end,
  input  ctl_cmd_t            cmd,
  output dp_stat_t            stat,
  output logic [MEAN_W-1:0]   out_row_mean,
  output logic [ROWNUM_W-1:0] out_row_number,
  output logic                out_is_peak_report,
  output logic                out_last
);

  localparam int CNT_W = $clog2(MAX_WIDTH + 1);
  localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // Frame state
  logic [SUM_W-1:0]    row_sum_r;
  logic [PIX_W-1:0]    prev_r;
  logic [CNT_W-1:0]    col_r;
  logic [RW-1:0]       row_cnt_r;
  logic [MEAN_W-1:0]   best_mean_r;
  logic [RW-1:0]       best_row_r;
  logic                have_best_r;
  logic                fend_r;

  // Divider and row result
  logic [CW:0]         rem_r;
  logic [MEAN_W-1:0]   low_r;
  logic [MEAN_W-1:0]   quo_r;
  logic [CW-1:0]       div_r;
  logic                ovf_r;
  logic [STEP_W-1:0]   step_r;
  logic [MEAN_W-1:0]   mean_r;
  logic [RW-1:0]       row_out_r;

  logic [CW-1:0]       rw_ext;
  logic [CW-1:0]       eff_w;
  logic [CW-1:0]       divisor;
  logic [PIX_W-1:0]    abs_diff;
  logic [PIX_W-1:0]    add_val;
  logic [SUM_W-1:0]    sum_acc;
  logic [CNT_W-1:0]    col_inc;
  logic                row_end;
  logic [CW:0]         trial;
  logic                trial_ge;
  logic [MEAN_W-1:0]   mean_fin;

  // Clamp width and pick divisor by mode
  always_comb begin
    rw_ext = CW'(row_width);
    if (rw_ext < CW'(2)) begin
      eff_w = CW'(2);
    end else if (rw_ext > CW'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = rw_ext;
    end
    divisor = diff_mode ? (eff_w - CW'(1)) : eff_w;
  end

  // Accumulate incoming pixel
  always_comb begin
    abs_diff = (in_pixel >= prev_r) ? (in_pixel - prev_r) : (prev_r - in_pixel);
    if (diff_mode) begin
      add_val = (col_r != '0) ? abs_diff : '0;
    end else begin
      add_val = in_pixel;
    end
    sum_acc = row_sum_r + SUM_W'(add_val);
    col_inc = col_r + CNT_W'(1);
    row_end = CW'(col_inc) >= eff_w;
  end

  // One restoring step per cycle
  always_comb begin
    trial    = {rem_r[CW-1:0], low_r[MEAN_W-1]};
    trial_ge = trial >= {1'b0, div_r};
    mean_fin = ovf_r ? '1 : quo_r;
  end

  // Frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      row_sum_r   <= '0;
      prev_r      <= '0;
      col_r       <= '0;
      row_cnt_r   <= '0;
      best_mean_r <= '0;
      best_row_r  <= '0;
      have_best_r <= 1'b0;
      fend_r      <= 1'b0;
    end else begin
      if (cmd.take) begin
        prev_r <= in_pixel;
        fend_r <= in_frame_end;
        if (row_end) begin
          row_sum_r <= '0;
          col_r     <= '0;
        end else begin
          row_sum_r <= sum_acc;
          col_r     <= col_inc;
        end
      end
      if (cmd.finish) begin
        if (!have_best_r || (mean_fin > best_mean_r)) begin
          best_mean_r <= mean_fin;
          best_row_r  <= row_cnt_r;
          have_best_r <= 1'b1;
        end
        if (row_cnt_r < RW'(MAX_ROWS - 1)) begin
          row_cnt_r <= row_cnt_r + RW'(1);
        end
      end
    end
  end

  // Load divider on each taken pixel, step one quotient bit a cycle; latch result
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rem_r  <= (CW + 1)'(sum_acc[SUM_W-1:MEAN_W]);
      low_r  <= sum_acc[MEAN_W-1:0];
      div_r  <= divisor;
      ovf_r  <= (CW + 1)'(sum_acc[SUM_W-1:MEAN_W]) >= {1'b0, divisor};
      step_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= trial_ge ? (trial - {1'b0, div_r}) : trial;
      low_r  <= {low_r[MEAN_W-2:0], 1'b0};
      quo_r  <= {quo_r[MEAN_W-2:0], trial_ge};
      step_r <= step_r + STEP_W'(1);
    end
    if (cmd.finish) begin
      mean_r    <= mean_fin;
      row_out_r <= row_cnt_r;
    end
  end

  // Status and result fields
  always_comb begin
    stat.row_end       = row_end;
    stat.div_last      = (step_r == STEP_W'(MEAN_W - 1));
    stat.fend          = fend_r;
    out_row_mean       = cmd.show_rep ? best_mean_r : mean_r;
    out_row_number     = cmd.show_rep ? ROWNUM_W'(best_row_r) : ROWNUM_W'(row_out_r);
    out_is_peak_report = cmd.show_rep;
    out_last           = cmd.show_rep || !fend_r;
  end

endmodule

FILE: hdl/row_projection_peak_locator_unit.sv
// Top level of the row projection peak locator: configuration registers,
// controller and datapath. Depends on rppl_pkg, rppl_ctrl and rppl_dp.
//
//  channel   direction  handshake                 payload
//  in_       input      in_valid / in_ready       in_pixel, in_frame_end
//  out_      output     out_valid / out_ready     out_row_mean, out_row_number,
//                                                 out_is_peak_report, out_last
//  cfg_      input      cfg_valid / cfg_ready     cfg_index, cfg_data
//
// A pixel that does not end a row is taken without leaving the idle state. A
// row-ending pixel runs the shared bit-serial divider, then a closing state,
// then holds its result until taken before the next pixel is accepted. A
// frame end adds a peak report state. Output stalls hold the block.
// Reset is synchronous, active low, and needs no clearing pass; row_width
// resets to 640 and diff_mode to 0. Configuration writes are always taken.
module row_projection_peak_locator_unit
  import rppl_pkg::*;
#(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_ROWS  = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_pixel,
  input  logic                 in_frame_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [MEAN_W-1:0]    out_row_mean,
  output logic [ROWNUM_W-1:0]  out_row_number,
  output logic                 out_is_peak_report,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0] row_width_r;
  logic             diff_mode_r;
  ctl_cmd_t         cmd;
  dp_stat_t         stat;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_WIDTH_RST;
      diff_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROW_WIDTH: row_width_r <= cfg_data;
        REG_DIFF_MODE: diff_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rppl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_frame_end (in_frame_end),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  rppl_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_ROWS  (MAX_ROWS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .row_width          (row_width_r),
    .diff_mode          (diff_mode_r),
    .in_pixel           (in_pixel),
    .in_frame_end       (in_frame_end),
    .cmd                (cmd),
    .stat               (stat),
    .out_row_mean       (out_row_mean),
    .out_row_number     (out_row_number),
    .out_is_peak_report (out_is_peak_report),
    .out_last           (out_last)
  );

endmodule
